FILE: rtl/core/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// No dependencies; every other file of the block imports it.
package sfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 8'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;

    // Frame parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_CMD     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CSUM    = 3'd6
    } phase_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Header bytes handed to the parser
    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
    } hdr_cfg_t;

    // One parser result
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  payload_length;
        logic              checksum_ok;
        logic              last;
    } result_t;

endpackage

FILE: rtl/core/sfd_rx_if.sv
// Received byte channel of the serial frame deframer.
// Depends on sfd_pkg for field widths.
interface sfd_rx_if
    import sfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/sfd_res_if.sv
// Result channel of the serial frame deframer.
// Depends on sfd_pkg for field widths.
interface sfd_res_if
    import sfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  payload_length;
    logic              checksum_ok;
    logic              last;

    modport source (output valid, output kind, output data_byte, output command,
                    output payload_length, output checksum_ok, output last,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input command,
                    input payload_length, input checksum_ok, input last,
                    output ready);
endinterface

FILE: rtl/core/sfd_cfg_if.sv
// Configuration write channel of the serial frame deframer.
// Depends on sfd_pkg for field widths.
interface sfd_cfg_if
    import sfd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/sfd_parser.sv
// Frame parser: phase state, length, byte count, running sum and command,
// with the per-byte result. Depends on sfd_pkg.
module sfd_parser
    import sfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] in_byte,
    input  hdr_cfg_t          hdr,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [LEN_W-1:0]  payload_count;

    // Derive payload byte count from the length field
    assign payload_count = (frame_length_reg > LEN_W'(1)) ? frame_length_reg - LEN_W'(1)
                                                          : '0;

    // Compute next parser state
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_left_next   = bytes_left_reg;
        running_sum_next  = running_sum_reg;
        command_next      = command_reg;
        case (phase_reg)
            PH_HDR2:
            begin
                phase_next = (in_byte == hdr.header_second) ? PH_LEN_LO : PH_HUNT;
            end
            PH_LEN_LO:
            begin
                frame_length_next = {{(LEN_W-BYTE_W){1'b0}}, in_byte};
                running_sum_next  = in_byte;
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_length_next = {in_byte, frame_length_reg[BYTE_W-1:0]};
                running_sum_next  = running_sum_reg + in_byte;
                phase_next        = PH_CMD;
            end
            PH_CMD:
            begin
                command_next     = in_byte;
                running_sum_next = running_sum_reg + in_byte;
                bytes_left_next  = payload_count;
                phase_next       = (payload_count != '0) ? PH_PAYLOAD : PH_CSUM;
            end
            PH_PAYLOAD:
            begin
                running_sum_next = running_sum_reg + in_byte;
                bytes_left_next  = bytes_left_reg - LEN_W'(1);
                if (bytes_left_reg == LEN_W'(1))
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (in_byte == hdr.header_first) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    // Build the result for the current byte
    always_comb
    begin
        result = '{valid: 1'b0, kind: KIND_DATA, data_byte: '0, command: '0,
                   payload_length: '0, checksum_ok: 1'b0, last: 1'b0};
        case (phase_reg)
            PH_HDR2:
            begin
                if (in_byte != hdr.header_second)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_ERROR;
                    result.last  = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                result.valid          = 1'b1;
                result.kind           = KIND_DATA;
                result.data_byte      = in_byte;
                result.command        = command_reg;
                result.payload_length = payload_count;
            end
            PH_CSUM:
            begin
                result.valid          = 1'b1;
                result.kind           = KIND_END;
                result.command        = command_reg;
                result.payload_length = payload_count;
                result.checksum_ok    = (running_sum_reg == in_byte);
                result.last           = 1'b1;
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

    // Advance state on each byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= '0;
            bytes_left_reg   <= '0;
            running_sum_reg  <= '0;
            command_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_left_reg   <= bytes_left_next;
            running_sum_reg  <= running_sum_next;
            command_reg      <= command_next;
        end
    end

endmodule

FILE: rtl/core/serial_frame_deframer.sv
// Top level of the serial frame deframer: input register, parser, result
// register and header configuration. Depends on sfd_pkg, the channel
// interfaces and sfd_parser.
//
// Accepts one received byte per cycle while the result side does not stall.
// Each byte is held in the input register, then the parser updates its
// state and, for payload bytes, the checksum byte and a bad second header,
// loads the result register that drives the result channel. Header
// hunting, the header bytes, the length and command bytes give no result.
// The input keeps taking bytes while a result waits, until both registers
// are full and the result side stalls. Header bytes are writable at index 0
// and 1; other indexes are ignored.
module serial_frame_deframer
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sfd_rx_if.sink    rx,
    sfd_res_if.source res,
    sfd_cfg_if.sink   cfg
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic              advance;
    hdr_cfg_t          hdr;
    result_t           result;

    // Move the held byte through the parser when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign hdr.header_first  = header_first_reg;
    assign hdr.header_second = header_second_reg;

    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .hdr     (hdr),
        .result  (result)
    );

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Load or drop the result request
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = result.valid;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_reg.kind;
    assign res.data_byte      = out_reg.data_byte;
    assign res.command        = out_reg.command;
    assign res.payload_length = out_reg.payload_length;
    assign res.checksum_ok    = out_reg.checksum_ok;
    assign res.last           = out_reg.last;

    // Write header registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_HEADER_FIRST)
            begin
                header_first_reg <= cfg.data;
            end
            else if (cfg.index == CFG_HEADER_SECOND)
            begin
                header_second_reg <= cfg.data;
            end
        end
    end

endmodule

FILE: sim/sfd_frame_checker.sv
// Checker for the serial frame deframer: predicts each result from the
// accepted bytes and compares it with what the result channel delivers.
// Depends on sfd_pkg and the rx, result and configuration interfaces.
module sfd_frame_checker
    import sfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sfd_rx_if    rx,
    sfd_res_if   res,
    sfd_cfg_if   cfg,
    output int   fail_count,
    output int   pending,
    output int   n_data,
    output int   n_frames_good,
    output int   n_frames_bad,
    output int   n_hdr_err
);

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  payload_length;
        logic              checksum_ok;
        logic              last;
    } deframe_result_t;

    deframe_result_t   expected_q[$];

    // Mirror of the parser state and the header registers
    phase_t            parse_phase;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  bytes_left;
    logic [BYTE_W-1:0] run_sum;
    logic [BYTE_W-1:0] cur_cmd;
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;

    // Advance the parser mirror by one byte and queue any result it causes
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        deframe_result_t  r;
        logic [LEN_W-1:0] plen;
        plen = (frame_len > 16'd1) ? frame_len - 16'd1 : '0;
        r = '0;
        case (parse_phase)
            PH_HDR2:
            begin
                if (b != hdr_second)
                begin
                    r.kind = KIND_ERROR;
                    r.last = 1'b1;
                    expected_q.push_back(r);
                    n_hdr_err++;
                    parse_phase = PH_HUNT;
                end
                else
                begin
                    parse_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                frame_len   = {8'h00, b};
                run_sum     = b;
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len[15:8] = b;
                run_sum         = run_sum + b;
                parse_phase     = PH_CMD;
            end
            PH_CMD:
            begin
                cur_cmd     = b;
                run_sum     = run_sum + b;
                bytes_left  = plen;
                parse_phase = (plen != 0) ? PH_PAYLOAD : PH_CSUM;
            end
            PH_PAYLOAD:
            begin
                run_sum          = run_sum + b;
                r.kind           = KIND_DATA;
                r.data_byte      = b;
                r.command        = cur_cmd;
                r.payload_length = plen;
                expected_q.push_back(r);
                n_data++;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0)
                    parse_phase = PH_CSUM;
            end
            PH_CSUM:
            begin
                r.kind           = KIND_END;
                r.command        = cur_cmd;
                r.payload_length = plen;
                r.checksum_ok    = (run_sum == b);
                r.last           = 1'b1;
                expected_q.push_back(r);
                if (r.checksum_ok)
                    n_frames_good++;
                else
                    n_frames_bad++;
                parse_phase = PH_HUNT;
            end
            default:
            begin
                // hunt: anything but the first header byte is dropped
                parse_phase = (b == hdr_first) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    endtask

    // Compare one delivered result with the oldest prediction
    task automatic check_result();
        deframe_result_t exp_r;
        if (expected_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("sfd_frame_checker: result with none predicted: kind=%0d data=%02h",
                         res.kind, res.data_byte);
        end
        else
        begin
            exp_r = expected_q.pop_front();
            if (res.kind !== exp_r.kind || res.data_byte !== exp_r.data_byte ||
                res.command !== exp_r.command ||
                res.payload_length !== exp_r.payload_length ||
                res.checksum_ok !== exp_r.checksum_ok || res.last !== exp_r.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("sfd_frame_checker: expected kind=%0d data=%02h cmd=%02h len=%0d ok=%0b last=%0b",
                             exp_r.kind, exp_r.data_byte, exp_r.command,
                             exp_r.payload_length, exp_r.checksum_ok, exp_r.last);
                    $display("sfd_frame_checker:      got kind=%0d data=%02h cmd=%02h len=%0d ok=%0b last=%0b",
                             res.kind, res.data_byte, res.command,
                             res.payload_length, res.checksum_ok, res.last);
                end
            end
        end
    endtask

    // Watch every channel on the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            parse_phase   = PH_HUNT;
            frame_len     = '0;
            bytes_left    = '0;
            run_sum       = '0;
            cur_cmd       = '0;
            hdr_first     = HEADER_FIRST_RST;
            hdr_second    = HEADER_SECOND_RST;
            fail_count    = 0;
            n_data        = 0;
            n_frames_good = 0;
            n_frames_bad  = 0;
            n_hdr_err     = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_HEADER_FIRST)
                    hdr_first = cfg.data;
                else if (cfg.index == CFG_HEADER_SECOND)
                    hdr_second = cfg.data;
            end
            if (res.valid && res.ready)
                check_result();
            if (rx.valid && rx.ready)
                deframe_byte(rx.rx_byte);
            pending <= expected_q.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the serial frame deframer testbench: clock, reset, byte and
// configuration stimulus, result-side stalls, watchdog and verdict.
// Depends on sfd_pkg, the channel interfaces, the block and sfd_frame_checker.
module testbench
    import sfd_pkg::*;
();

    localparam int HOLD_CYCLES  = 400;
    localparam int WDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 170;
    localparam int NUM_PHASES   = 7;

    logic clk;
    logic rst_n;

    sfd_rx_if  rx_ch ();
    sfd_res_if res_ch ();
    sfd_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int n_data;
    int n_frames_good;
    int n_frames_bad;
    int n_hdr_err;

    // Stimulus controls shared by the sender and the receiver
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;
    int idle_cycles;
    int bytes_sent;

    logic [BYTE_W-1:0] byte_q[$];
    logic [BYTE_W-1:0] cur_first;
    logic [BYTE_W-1:0] cur_second;

    serial_frame_deframer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    sfd_frame_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .res           (res_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_data        (n_data),
        .n_frames_good (n_frames_good),
        .n_frames_bad  (n_frames_bad),
        .n_hdr_err     (n_hdr_err)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly short frames, a few with a nonzero upper length byte
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return LEN_W'($urandom_range(0, 1));
        else if (r < 70)
            return LEN_W'($urandom_range(2, 9));
        else if (r < 95)
            return LEN_W'($urandom_range(10, 40));
        return LEN_W'($urandom_range(256, 270));
    endfunction

    // Queue one complete frame under the current header bytes
    task automatic add_frame(input logic [LEN_W-1:0] len, input bit good,
                             input logic [BYTE_W-1:0] cmd);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                n;
        byte_q.push_back(cur_first);
        byte_q.push_back(cur_second);
        byte_q.push_back(len[7:0]);
        byte_q.push_back(len[15:8]);
        byte_q.push_back(cmd);
        sum = len[7:0] + len[15:8] + cmd;
        n = (len > LEN_W'(1)) ? int'(len) - 1 : 0;
        repeat (n)
        begin
            b = BYTE_W'($urandom);
            byte_q.push_back(b);
            sum = sum + b;
        end
        if (!good)
            sum = sum ^ (BYTE_W'(1) << $urandom_range(0, 7));
        byte_q.push_back(sum);
    endtask

    // Queue a first header byte followed by a wrong second byte
    task automatic add_header_error();
        logic [BYTE_W-1:0] b;
        byte_q.push_back(cur_first);
        if (cur_first != cur_second && $urandom_range(0, 3) == 0)
        begin
            byte_q.push_back(cur_first);
        end
        else
        begin
            b = BYTE_W'($urandom);
            while (b == cur_second)
                b = BYTE_W'($urandom);
            byte_q.push_back(b);
        end
    endtask

    // Offer every queued byte, with idle gaps between requests
    task automatic send_bytes();
        int gap;
        while (byte_q.size() > 0)
        begin
            gap = tx_idle_en ? pick_gap() : 0;
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= byte_q.pop_front();
            @(posedge clk);
            while (!rx_ch.ready)
                @(posedge clk);
            bytes_sent++;
        end
    endtask

    // Drop valid, wait for every predicted result, then let the pipe settle
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_HEADER_FIRST)
            cur_first = val;
        else if (idx == CFG_HEADER_SECOND)
            cur_second = val;
        @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = rx_idle_en ? pick_gap() : 0;
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // End the run when nothing has been accepted for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request accepted for %0d cycles, %0d results still due",
                 WDOG_LIMIT, pending);
        $display("[serial_frame_deframer] ERROR");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int r;
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0]  len;

        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        cur_first     = HEADER_FIRST_RST;
        cur_second    = HEADER_SECOND_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dropped bytes, both header mismatches, short and normal frames
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(cur_first);
        byte_q.push_back(8'h00);
        byte_q.push_back(cur_first);
        byte_q.push_back(cur_first);
        byte_q.push_back(cur_second);
        add_frame(16'd0, 1'b1, 8'hFF);
        add_frame(16'd1, 1'b0, 8'h00);
        add_frame(16'd3, 1'b1, 8'hA5);
        send_bytes();

        // Random phases, each under its own header setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    write_reg(CFG_HEADER_FIRST, 8'h00);
                    write_reg(CFG_HEADER_SECOND, 8'hFF);
                end
                1:
                begin
                    write_reg(CFG_HEADER_FIRST, 8'hFF);
                    write_reg(CFG_HEADER_SECOND, 8'h00);
                end
                2:
                begin
                    write_reg(CFG_HEADER_FIRST, 8'h7E);
                    write_reg(CFG_HEADER_SECOND, 8'h7E);
                end
                3:
                begin
                    write_reg(CFG_HEADER_FIRST, HEADER_FIRST_RST);
                    write_reg(CFG_HEADER_SECOND, HEADER_SECOND_RST);
                end
                default:
                begin
                    write_reg(CFG_HEADER_FIRST, BYTE_W'($urandom));
                    write_reg(CFG_HEADER_SECOND, BYTE_W'($urandom));
                end
            endcase
            // an index past the last register must leave both headers alone
            write_reg(CFG_INDEX_W'($urandom_range(int'(CFG_HEADER_SECOND) + 1, 255)),
                      BYTE_W'($urandom));

            // fill the block against a stalled result side once
            hold_req   = (p == 3);
            tx_idle_en = (p != 3) && (p != 5);
            rx_idle_en = (p != 5);

            while (byte_q.size() < PHASE_BYTES)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    add_frame(pick_length(), $urandom_range(0, 99) < 85, BYTE_W'($urandom));
                end
                else if (r < 80)
                begin
                    add_header_error();
                end
                else if (r < 92)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        b = BYTE_W'($urandom);
                        if (b != cur_first)
                            byte_q.push_back(b);
                    end
                end
                else
                begin
                    // broken frame: cut short, the next bytes complete it
                    len = LEN_W'($urandom_range(0, 15));
                    byte_q.push_back(cur_first);
                    byte_q.push_back(cur_second);
                    byte_q.push_back(len[7:0]);
                    byte_q.push_back(len[15:8]);
                    repeat ($urandom_range(0, 4))
                        byte_q.push_back(BYTE_W'($urandom));
                end
            end
            send_bytes();
        end

        // One frame with a nonzero upper length byte, both sides without idling
        wait_idle();
        write_reg(CFG_HEADER_FIRST, BYTE_W'($urandom));
        write_reg(CFG_HEADER_SECOND, BYTE_W'($urandom));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        add_frame(16'h0100, 1'b1, BYTE_W'($urandom));
        send_bytes();

        wait_idle();
        $display("run: %0d bytes sent, %0d payload bytes, %0d good and %0d bad frames,",
                 bytes_sent, n_data, n_frames_good, n_frames_bad);
        $display("run: %0d header mismatches, %0d header settings, %0d failures",
                 n_hdr_err, NUM_PHASES + 2, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("[serial_frame_deframer] OK");
        else
            $display("[serial_frame_deframer] ERROR");
        $finish;
    end

endmodule
